// File: hw/rtl/dorq_pkg.sv
// Shared types and constants for the drop-oldest ring queue.
`timescale 1ns / 1ps

package dorq_pkg;

  localparam int DATA_W = 32;
  localparam int SLOT_W = 4;
  localparam int DROP_W = 5;

  typedef enum logic {
    REQ_PUSH    = 1'b0,
    REQ_ACQUIRE = 1'b1
  } req_t;

  typedef struct packed {
    req_t              req_type;
    logic [DATA_W-1:0] entry_data;
  } in_beat_t;

  typedef struct packed {
    logic [DATA_W-1:0] out_data;
    logic [SLOT_W-1:0] out_slot;
    logic [DROP_W-1:0] dropped;
    logic              is_empty;
  } out_beat_t;

endpackage

// File: hw/rtl/drop_oldest_ring_queue_top.sv
// Top level of the drop-oldest ring queue of descriptor words.
`timescale 1ns / 1ps

// Drop-oldest ring FIFO. Each input beat is a push or an acquire and yields
// exactly one result beat, in the cycle after it is accepted; a new beat can be
// accepted every cycle, also while the previous result waits in the output
// register, as long as that register is being taken. The index and count
// update is one short step per beat and the descriptor store is a single
// RAM with registered read, touched at most once per beat (write on push, read on
// acquire). A push that finds more than QUEUE_LIMIT entries first drops the
// oldest ones down to DROP_TARGET; a push landing on the slot being sent
// skips over it. An acquire on an empty ring returns is_empty and changes
// nothing. Slots are never cleared after reset; the store needs no init pass.
module drop_oldest_ring_queue_top
  import dorq_pkg::*;
#(
  parameter int QUEUE_LIMIT = 14,
  parameter int RING_DEPTH  = 16,
  parameter int DROP_TARGET = 7
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_beat,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_beat
);

  localparam int IDX_W    = $clog2(RING_DEPTH);
  localparam int FILL_MAX = ((QUEUE_LIMIT > DROP_TARGET) ? QUEUE_LIMIT : DROP_TARGET) + 2;
  localparam int CNT_W    = $clog2(FILL_MAX + 1);

  // Read-index step taken by a drop, per pre-drop fill count, mod RING_DEPTH.
  function automatic logic [(FILL_MAX+1)*IDX_W-1:0] drop_step_tbl();
    logic [(FILL_MAX+1)*IDX_W-1:0] tbl;
    int k;
    tbl = '0;
    for (k = DROP_TARGET + 1; k <= FILL_MAX; k++) begin
      tbl[k*IDX_W +: IDX_W] = IDX_W'((k - DROP_TARGET) % RING_DEPTH);
    end
    return tbl;
  endfunction

  localparam logic [(FILL_MAX+1)*IDX_W-1:0] DROP_TBL = drop_step_tbl();

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(RING_DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  // ring state
  logic [IDX_W-1:0] wr_idx_r, wr_idx_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [IDX_W-1:0] send_slot_r, send_slot_nxt;
  logic             send_vld_r, send_vld_nxt;

  // output stage
  logic              out_valid_r, out_valid_nxt;
  logic              out_acq_r, out_acq_nxt;
  logic [SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic [DROP_W-1:0] out_drop_r, out_drop_nxt;
  logic              out_empty_r, out_empty_nxt;

  logic              accept;
  logic              is_acq;
  logic              drop_hit;
  logic [CNT_W-1:0]  drop_cnt;
  logic [IDX_W-1:0]  drop_step;
  logic [IDX_W:0]    rd_sum;
  logic [IDX_W-1:0]  rd_after_drop;
  logic [CNT_W-1:0]  fill_after_drop;
  logic              skip;
  logic [IDX_W-1:0]  wr_slot;
  logic              ram_wr_en;
  logic              ram_rd_en;
  logic [DATA_W-1:0] ram_rd_data;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign is_acq   = (in_beat.req_type == REQ_ACQUIRE);

  assign drop_hit  = (fill_r > CNT_W'(QUEUE_LIMIT)) && (fill_r > CNT_W'(DROP_TARGET));
  assign drop_cnt  = fill_r - CNT_W'(DROP_TARGET);
  assign drop_step = DROP_TBL[fill_r*IDX_W +: IDX_W];
  assign rd_sum    = {1'b0, rd_idx_r} + {1'b0, drop_step};
  assign rd_after_drop = (rd_sum >= (IDX_W+1)'(RING_DEPTH)) ?
                         IDX_W'(rd_sum - (IDX_W+1)'(RING_DEPTH)) : IDX_W'(rd_sum);
  assign fill_after_drop = drop_hit ? CNT_W'(DROP_TARGET) : fill_r;

  assign skip    = send_vld_r && (wr_idx_r == send_slot_r);
  assign wr_slot = skip ? next_idx(wr_idx_r) : wr_idx_r;

  always_comb begin
    wr_idx_nxt    = wr_idx_r;
    rd_idx_nxt    = rd_idx_r;
    fill_nxt      = fill_r;
    send_slot_nxt = send_slot_r;
    send_vld_nxt  = send_vld_r;
    ram_wr_en     = 1'b0;
    ram_rd_en     = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_acq_nxt   = out_acq_r;
    out_slot_nxt  = out_slot_r;
    out_drop_nxt  = out_drop_r;
    out_empty_nxt = out_empty_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
      out_acq_nxt   = 1'b0;
      out_slot_nxt  = '0;
      out_drop_nxt  = '0;
      out_empty_nxt = 1'b0;
      if (!is_acq) begin
        ram_wr_en    = 1'b1;
        rd_idx_nxt   = drop_hit ? rd_after_drop : rd_idx_r;
        wr_idx_nxt   = next_idx(wr_slot);
        fill_nxt     = fill_after_drop + (skip ? CNT_W'(2) : CNT_W'(1));
        out_slot_nxt = SLOT_W'(wr_slot);
        out_drop_nxt = drop_hit ? DROP_W'(drop_cnt) : '0;
      end else if (fill_r == '0) begin
        out_empty_nxt = 1'b1;
      end else begin
        ram_rd_en     = 1'b1;
        send_slot_nxt = rd_idx_r;
        send_vld_nxt  = 1'b1;
        rd_idx_nxt    = next_idx(rd_idx_r);
        fill_nxt      = fill_r - 1'b1;
        out_acq_nxt   = 1'b1;
        out_slot_nxt  = SLOT_W'(rd_idx_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r    <= '0;
      rd_idx_r    <= '0;
      fill_r      <= '0;
      send_slot_r <= '0;
      send_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      wr_idx_r    <= wr_idx_nxt;
      rd_idx_r    <= rd_idx_nxt;
      fill_r      <= fill_nxt;
      send_slot_r <= send_slot_nxt;
      send_vld_r  <= send_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_acq_r   <= out_acq_nxt;
    out_slot_r  <= out_slot_nxt;
    out_drop_r  <= out_drop_nxt;
    out_empty_r <= out_empty_nxt;
  end

  dorq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (RING_DEPTH)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (wr_slot),
    .wr_data (in_beat.entry_data),
    .rd_en   (ram_rd_en),
    .rd_addr (rd_idx_r),
    .rd_data (ram_rd_data)
  );

  // read data stays put while the result beat is stalled: no read is issued then
  assign out_valid         = out_valid_r;
  assign out_beat.out_data = out_acq_r ? ram_rd_data : '0;
  assign out_beat.out_slot = out_slot_r;
  assign out_beat.dropped  = out_drop_r;
  assign out_beat.is_empty = out_empty_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(FILL_MAX))
    else $error("fill count above its bound");

  a_empty_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_acq && fill_r == '0) |=>
      (out_valid && out_beat.is_empty && $stable(rd_idx_r) && $stable(wr_idx_r)
       && $stable(fill_r)))
    else $error("empty acquire changed ring state or gave no empty result");

  a_drop_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !is_acq && drop_hit) |=>
      (fill_r == CNT_W'(DROP_TARGET + 1) || fill_r == CNT_W'(DROP_TARGET + 2)))
    else $error("fill count after drop is off target");

  a_send_mark: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_acq && fill_r != '0) |=>
      (send_vld_r && send_slot_r == $past(rd_idx_r)))
    else $error("acquire did not mark the sending slot");

endmodule

// File: hw/rtl/dorq_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module dorq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: bench/drop_oldest_ring_queue_top_tb.sv
// Self-checking testbench for the drop-oldest ring queue top level.
`timescale 1ns / 1ps

module drop_oldest_ring_queue_top_tb;
  import dorq_pkg::*;

  localparam int QUEUE_LIMIT = 14;
  localparam int RING_DEPTH  = 16;
  localparam int DROP_TARGET = 7;
  localparam int IDLE_LIMIT  = 2000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_beat = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_beat;

  // Ring image: words, which slots hold a pushed word, indexes and fill level.
  logic [DATA_W-1:0] ring_words [RING_DEPTH];
  bit                ring_written [RING_DEPTH];
  int                wr_ptr = 0;
  int                rd_ptr = 0;
  int                fill_level = 0;
  int                tx_slot = 0;
  bit                tx_marked = 1'b0;

  out_beat_t pending_results[$];
  int        mismatch_count = 0;
  bit        tx_idle_en = 1'b1;
  bit        rx_idle_en = 1'b1;
  int        rx_hold_cycles = 0;

  drop_oldest_ring_queue_top #(
    .QUEUE_LIMIT(QUEUE_LIMIT),
    .RING_DEPTH (RING_DEPTH),
    .DROP_TARGET(DROP_TARGET)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_beat  (in_beat),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_beat (out_beat)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Advances the ring image by one beat and returns the result it must give.
  function automatic out_beat_t predict_queue_result(in_beat_t beat);
    out_beat_t res;
    int        s;
    int        n;
    res = '0;
    if (beat.req_type == REQ_PUSH) begin
      if (fill_level > QUEUE_LIMIT && fill_level > DROP_TARGET) begin
        n = fill_level - DROP_TARGET;
        rd_ptr = (rd_ptr + n) % RING_DEPTH;
        fill_level = DROP_TARGET;
        res.dropped = n[DROP_W-1:0];
      end
      s = wr_ptr;
      wr_ptr = (wr_ptr + 1) % RING_DEPTH;
      fill_level++;
      // slot still on the wire: hop over it, the hole stays counted
      if (tx_marked && s == tx_slot) begin
        s = wr_ptr;
        wr_ptr = (wr_ptr + 1) % RING_DEPTH;
        fill_level++;
      end
      ring_words[s] = beat.entry_data;
      ring_written[s] = 1'b1;
      res.out_slot = s[SLOT_W-1:0];
    end else if (fill_level == 0) begin
      res.is_empty = 1'b1;
    end else begin
      s = rd_ptr;
      tx_slot = s;
      tx_marked = 1'b1;
      rd_ptr = (rd_ptr + 1) % RING_DEPTH;
      fill_level--;
      res.out_data = ring_words[s];
      res.out_slot = s[SLOT_W-1:0];
    end
    return res;
  endfunction

  function automatic void check_field(string name, logic [DATA_W-1:0] want,
                                      logic [DATA_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // Offers one beat, holds it until taken, then records its expected result.
  task automatic send_beat(input req_t req, input logic [DATA_W-1:0] word);
    int       gap;
    in_beat_t beat;
    gap = tx_idle_en ? $urandom_range(0, 15) : 0;
    // never let an acquire read a slot that was never written
    if (req == REQ_ACQUIRE && fill_level != 0 && !ring_written[rd_ptr]) req = REQ_PUSH;
    beat.req_type = req;
    beat.entry_data = word;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(predict_queue_result(beat));
  endtask

  // Receiver: before each beat it takes, stalls for a random number of cycles when idling is on, or for a set hold.
  initial begin : receiver
    int w;
    @(posedge clk);
    forever begin
      w = rx_idle_en ? $urandom_range(0, 15) : 0;
      if (rx_hold_cycles > 0) begin
        w = rx_hold_cycles;
        rx_hold_cycles = 0;
      end
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin : result_check
    out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat: expected none, actual %p", $time, out_beat);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("out_data", want.out_data, out_beat.out_data);
        check_field("out_slot", DATA_W'(want.out_slot), DATA_W'(out_beat.out_slot));
        check_field("dropped", DATA_W'(want.dropped), DATA_W'(out_beat.dropped));
        check_field("is_empty", DATA_W'(want.is_empty), DATA_W'(out_beat.is_empty));
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  task automatic test_empty_acquire();
    send_beat(REQ_ACQUIRE, '1);
  endtask

  task automatic test_fifo_order();
    send_beat(REQ_PUSH, '0);
    send_beat(REQ_PUSH, '1);
    send_beat(REQ_PUSH, 32'hA5A5_5A5A);
    repeat (3) send_beat(REQ_ACQUIRE, $urandom);
    send_beat(REQ_ACQUIRE, '0);
  endtask

  // Ring now sits at write 3, read 3, slot 2 marked. Fifteen pushes fill it
  // past the limit; the sixteenth drops to the target, finds slot 2 marked,
  // skips it and lands on slot 3.
  task automatic test_drop_and_skip();
    repeat (16) send_beat(REQ_PUSH, $urandom);
  endtask

  task automatic test_backpressure();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    rx_hold_cycles = 300;
    repeat (40) send_beat(($urandom_range(0, 99) < 70) ? REQ_PUSH : REQ_ACQUIRE, $urandom);
  endtask

  task automatic test_random_mix(input int count, input int push_pct,
                                 input bit tx_idle, input bit rx_idle);
    tx_idle_en = tx_idle;
    rx_idle_en = rx_idle;
    repeat (count)
      send_beat(($urandom_range(0, 99) < push_pct) ? REQ_PUSH : REQ_ACQUIRE, $urandom);
  endtask

  initial begin : main
    for (int i = 0; i < RING_DEPTH; i++) begin
      ring_words[i] = '0;
      ring_written[i] = 1'b0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_acquire();
    test_fifo_order();
    test_drop_and_skip();
    test_backpressure();
    test_random_mix(400, 50, 1'b1, 1'b1);
    test_random_mix(400, 70, 1'b0, 1'b0);
    test_random_mix(300, 35, 1'b1, 1'b0);
    test_random_mix(300, 60, 1'b0, 1'b1);
    test_random_mix(210, 55, 1'b1, 1'b1);

    // drop valid at the edge that took the last beat so it is not taken twice
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/dorq_pkg.sv
hw/rtl/dorq_ram.sv
hw/rtl/drop_oldest_ring_queue_top.sv
bench/drop_oldest_ring_queue_top_tb.sv
